FILE: rtl/core/assert_macros.svh
// Assertion macros for the RTL that carries checks; superfast_hash_32 includes them.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/shf_pkg.sv
// Shared types and constants for the SuperFastHash stream block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package shf_pkg;

  typedef logic [31:0] hash_t;
  typedef logic [31:0] word_t;
  typedef logic [2:0]  nbytes_t;

  localparam nbytes_t FULL_BYTES = 3'd4;

endpackage

`default_nettype wire

FILE: rtl/core/shf_front.sv
// Front end: accepts message items and runs the per-word mixing rounds and the tail rounds.
// Depends on shf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module shf_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_accept,
  input  wire shf_pkg::word_t  in_data_word,
  input  wire shf_pkg::nbytes_t in_valid_bytes,
  input  wire shf_pkg::word_t  in_message_length,
  input  wire logic            in_last_word,
  output logic                 q_push,
  output shf_pkg::hash_t       q_data
);

  function automatic shf_pkg::hash_t sext8(input logic [7:0] b);
    sext8 = {{24{b[7]}}, b};
  endfunction

  function automatic shf_pkg::hash_t full_round(input shf_pkg::hash_t h_in,
                                                input shf_pkg::word_t w);
    shf_pkg::hash_t h;
    shf_pkg::hash_t t;
    h = h_in + {16'd0, w[15:0]};
    t = {5'd0, w[31:16], 11'd0} ^ h;
    h = (h << 16) ^ t;
    h = h + (h >> 11);
    full_round = h;
  endfunction

  function automatic shf_pkg::hash_t tail3(input shf_pkg::hash_t h_in,
                                           input shf_pkg::word_t w);
    shf_pkg::hash_t h;
    h = h_in + {16'd0, w[15:0]};
    h = h ^ (h << 16);
    h = h ^ (sext8(w[23:16]) << 18);
    h = h + (h >> 11);
    tail3 = h;
  endfunction

  function automatic shf_pkg::hash_t tail2(input shf_pkg::hash_t h_in,
                                           input shf_pkg::word_t w);
    shf_pkg::hash_t h;
    h = h_in + {16'd0, w[15:0]};
    h = h ^ (h << 11);
    h = h + (h >> 17);
    tail2 = h;
  endfunction

  function automatic shf_pkg::hash_t tail1(input shf_pkg::hash_t h_in,
                                           input shf_pkg::word_t w);
    shf_pkg::hash_t h;
    h = h_in + sext8(w[7:0]);
    h = h ^ (h << 10);
    h = h + (h >> 1);
    tail1 = h;
  endfunction

  shf_pkg::hash_t run_r, run_nxt;
  logic           inside_r, inside_nxt;
  shf_pkg::hash_t h_seed;
  shf_pkg::hash_t h_full;
  shf_pkg::hash_t h_last;

  assign h_seed = inside_r ? run_r : in_message_length;
  assign h_full = full_round(h_seed, in_data_word);

  // Counts above four behave as a full word.
  always_comb begin
    if (in_valid_bytes >= shf_pkg::FULL_BYTES) begin
      h_last = h_full;
    end else begin
      case (in_valid_bytes[1:0])
        2'd3:    h_last = tail3(h_seed, in_data_word);
        2'd2:    h_last = tail2(h_seed, in_data_word);
        2'd1:    h_last = tail1(h_seed, in_data_word);
        // An empty message hashes to zero, and the finish maps zero to zero.
        default: h_last = inside_r ? h_seed : '0;
      endcase
    end
  end

  always_comb begin
    run_nxt    = run_r;
    inside_nxt = inside_r;
    if (in_accept) begin
      if (in_last_word) begin
        run_nxt    = '0;
        inside_nxt = 1'b0;
      end else begin
        run_nxt    = h_full;
        inside_nxt = 1'b1;
      end
    end
  end

  assign q_push = in_accept && in_last_word;
  assign q_data = h_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r    <= '0;
      inside_r <= 1'b0;
    end else begin
      run_r    <= run_nxt;
      inside_r <= inside_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/shf_fifo.sv
// Small register queue that decouples the front end from the finish pipeline.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module shf_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/shf_back.sv
// Back end: two-stage avalanche finish whose second stage is the result register.
// Depends on shf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module shf_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_empty,
  input  wire shf_pkg::hash_t q_data,
  output logic                q_pop,
  input  wire logic           out_pop,
  output logic                out_empty,
  output shf_pkg::hash_t      out_hash_value
);

  function automatic shf_pkg::hash_t finish_a(input shf_pkg::hash_t h_in);
    shf_pkg::hash_t h;
    h = h_in ^ (h_in << 3);
    h = h + (h >> 5);
    h = h ^ (h << 4);
    finish_a = h;
  endfunction

  function automatic shf_pkg::hash_t finish_b(input shf_pkg::hash_t h_in);
    shf_pkg::hash_t h;
    h = h_in + (h_in >> 17);
    h = h ^ (h << 25);
    h = h + (h >> 6);
    finish_b = h;
  endfunction

  shf_pkg::hash_t a_r, a_nxt;
  shf_pkg::hash_t b_r, b_nxt;
  logic           va_r, va_nxt;
  logic           vb_r, vb_nxt;
  logic           a_ready;
  logic           b_ready;

  // Each stage advances when the stage after it is empty or draining.
  assign b_ready = !vb_r || out_pop;
  assign a_ready = !va_r || b_ready;
  assign q_pop   = !q_empty && a_ready;

  always_comb begin
    a_nxt  = a_r;
    va_nxt = va_r;
    b_nxt  = b_r;
    vb_nxt = vb_r;
    if (a_ready) begin
      a_nxt  = finish_a(q_data);
      va_nxt = q_pop;
    end
    if (b_ready) begin
      b_nxt  = finish_b(a_r);
      vb_nxt = va_r;
    end
  end

  assign out_empty      = !vb_r;
  assign out_hash_value = b_r;

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= va_nxt;
      vb_r <= vb_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/superfast_hash_32.sv
// With the finish pipeline free, the hash of a message goes from the queue through finish
// stage a to stage b, which drives the result ports; other items produce no result.
// Throughput: one item per cycle while in_full is low, set by the combinational mixing round in the front end.
// A result not popped holds the pipeline; in_full rises once the queue of finished items fills.
// Reset (rst_n low, synchronous) clears the running hash, the message flag,
// the queue and the finish pipeline; no result is pending afterwards.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module superfast_hash_32 #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_push,
  output logic                  in_full,
  input  wire shf_pkg::word_t   in_data_word,
  input  wire shf_pkg::nbytes_t in_valid_bytes,
  input  wire shf_pkg::word_t   in_message_length,
  input  wire logic             in_last_word,
  output logic                  out_empty,
  input  wire logic             out_pop,
  output shf_pkg::hash_t        out_hash_value
);

  logic           in_accept;
  logic           q_push;
  shf_pkg::hash_t q_wdata;
  logic           q_full;
  logic           q_pop;
  shf_pkg::hash_t q_rdata;
  logic           q_empty;

  assign in_full   = q_full;
  assign in_accept = in_push && !in_full;

  shf_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_accept         (in_accept),
    .in_data_word      (in_data_word),
    .in_valid_bytes    (in_valid_bytes),
    .in_message_length (in_message_length),
    .in_last_word      (in_last_word),
    .q_push            (q_push),
    .q_data            (q_wdata)
  );

  shf_fifo #(
    .WIDTH ($bits(shf_pkg::hash_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  shf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_data         (q_rdata),
    .q_pop          (q_pop),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_hash_value (out_hash_value)
  );

  // A finished message must never be dropped at a full queue.
  `ASSERT_IMPLIES(a_no_overflow, clk, rst_n, q_push, !q_full, "queue overflow")
  // The finish pipeline only draws from a non-empty queue.
  `ASSERT_IMPLIES(a_no_underflow, clk, rst_n, q_pop, !q_empty, "queue underflow")
  // Nothing is pending right after reset.
  `ASSERT_IMPLIES(a_reset_empty, clk, rst_n, $past(!rst_n), out_empty && q_empty,
                  "result pending after reset")
  // A waiting result stays on the ports unchanged until it is popped.
  `ASSERT_NEXT(a_result_held, clk, rst_n, !out_empty && !out_pop,
               !out_empty && $stable(out_hash_value), "waiting result changed")

endmodule

`default_nettype wire

FILE: bench/superfast_hash_32_test.sv
// Self-checking testbench for superfast_hash_32: streams messages, predicts each hash and
// compares it with the popped results. Depends on shf_pkg and the superfast_hash_32 RTL.
`timescale 1ns / 1ps

module superfast_hash_32_test;

  localparam int RANDOM_ITEMS = 1450;
  localparam int DRAIN_CYCLES = 24;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_push;
  logic             in_full;
  shf_pkg::word_t   in_data_word;
  shf_pkg::nbytes_t in_valid_bytes;
  shf_pkg::word_t   in_message_length;
  logic             in_last_word;
  logic             out_empty;
  logic             out_pop;
  shf_pkg::hash_t   out_hash_value;

  // Predictor state and the hashes still owed by the block.
  shf_pkg::hash_t running_hash;
  bit             inside_msg;
  shf_pkg::hash_t expected_hashes[$];
  int             mismatch_count;
  int             items_sent;

  // Idle stretches: each side draws runs that are, at random, with or without random waits.
  int push_run_left;
  bit push_quiet;
  int pop_run_left;
  bit pop_quiet;

  superfast_hash_32 dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_data_word     (in_data_word),
    .in_valid_bytes   (in_valid_bytes),
    .in_message_length(in_message_length),
    .in_last_word     (in_last_word),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_hash_value   (out_hash_value)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic shf_pkg::hash_t sign_byte(logic [7:0] b);
    return {{24{b[7]}}, b};
  endfunction

  function automatic shf_pkg::hash_t mix_word(shf_pkg::hash_t h, shf_pkg::word_t w);
    shf_pkg::hash_t t;
    h = h + shf_pkg::hash_t'(w[15:0]);
    t = (shf_pkg::hash_t'(w[31:16]) << 11) ^ h;
    h = (h << 16) ^ t;
    h = h + (h >> 11);
    return h;
  endfunction

  function automatic shf_pkg::hash_t mix_tail(shf_pkg::hash_t h, shf_pkg::word_t w,
                                              shf_pkg::nbytes_t n);
    case (n)
      3'd3: begin
        h = h + shf_pkg::hash_t'(w[15:0]);
        h = h ^ (h << 16);
        h = h ^ (sign_byte(w[23:16]) << 18);
        h = h + (h >> 11);
      end
      3'd2: begin
        h = h + shf_pkg::hash_t'(w[15:0]);
        h = h ^ (h << 11);
        h = h + (h >> 17);
      end
      3'd1: begin
        h = h + sign_byte(w[7:0]);
        h = h ^ (h << 10);
        h = h + (h >> 1);
      end
      default: ;
    endcase
    return h;
  endfunction

  function automatic shf_pkg::hash_t avalanche(shf_pkg::hash_t h);
    h = h ^ (h << 3);
    h = h + (h >> 5);
    h = h ^ (h << 4);
    h = h + (h >> 17);
    h = h ^ (h << 25);
    h = h + (h >> 6);
    return h;
  endfunction

  // Advances the predictor by one accepted item and queues the hash it owes, if any.
  function automatic void absorb_item(shf_pkg::word_t w, shf_pkg::nbytes_t nb,
                                      shf_pkg::word_t len, logic last);
    shf_pkg::hash_t h;
    bit             first;
    first = !inside_msg;
    h = first ? len : running_hash;
    if (nb > shf_pkg::FULL_BYTES) nb = shf_pkg::FULL_BYTES;
    if (!last) begin
      running_hash = mix_word(h, w);
      inside_msg = 1'b1;
    end else begin
      if (first && nb == 3'd0) expected_hashes.push_back('0);
      else if (nb == shf_pkg::FULL_BYTES) expected_hashes.push_back(avalanche(mix_word(h, w)));
      else expected_hashes.push_back(avalanche(mix_tail(h, w, nb)));
      running_hash = '0;
      inside_msg = 1'b0;
    end
  endfunction

  function automatic int draw_gap(inout int run_left, inout bit quiet);
    if (run_left == 0) begin
      run_left = $urandom_range(1, 40);
      quiet = ($urandom_range(0, 2) == 0);
    end
    run_left--;
    return quiet ? 0 : $urandom_range(0, 15);
  endfunction

  task automatic report_failure(string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $realtime, what);
  endtask

  // Offers one item after a random wait and returns at the edge that accepts it.
  // push stays high on return so back-to-back items need no extra assignment.
  task automatic send_item(shf_pkg::word_t w, shf_pkg::nbytes_t nb, shf_pkg::word_t len,
                           logic last);
    int gap;
    gap = draw_gap(push_run_left, push_quiet);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push           <= 1'b1;
    in_data_word      <= w;
    in_valid_bytes    <= nb;
    in_message_length <= len;
    in_last_word      <= last;
    do @(posedge clk); while (in_full);
    absorb_item(w, nb, len, last);
    items_sent++;
  endtask

  task automatic test_single_item_messages();
    send_item($urandom, 3'd0, 32'd0, 1'b1);
    send_item(32'hFFFF_FFFF, 3'd0, 32'hFFFF_FFFF, 1'b1);
    send_item(32'hFFFF_FF7F, 3'd1, 32'd1, 1'b1);
    send_item(32'h0000_0080, 3'd1, 32'd1, 1'b1);
    send_item(32'h0000_00FF, 3'd1, 32'hFFFF_FFFF, 1'b1);
    send_item(32'hFFFF_FFFF, 3'd2, 32'd2, 1'b1);
    send_item(32'hFF80_1234, 3'd3, 32'd3, 1'b1);
    send_item(32'h007F_FFFF, 3'd3, 32'd3, 1'b1);
    send_item(32'hFFFF_FFFF, 3'd4, 32'hFFFF_FFFF, 1'b1);
    send_item(32'h0000_0000, 3'd4, 32'd0, 1'b1);
    send_item(32'hDEAD_BEEF, 3'd7, 32'd4, 1'b1);
  endtask

  task automatic test_multi_word_messages();
    send_item(32'hFFFF_FFFF, 3'd4, 32'd8, 1'b0);
    send_item(32'h0000_0000, 3'd4, 32'd8, 1'b1);
    // A short count on an item that is not last still mixes the whole word.
    send_item(32'h1234_5678, 3'd1, 32'd7, 1'b0);
    send_item(32'hEEA1_B2C3, 3'd3, 32'd0, 1'b1);
    // Zero bytes ending a longer message only apply the finish.
    send_item(32'h89AB_CDEF, 3'd4, 32'd4, 1'b0);
    send_item(32'hFFFF_FFFF, 3'd0, 32'd4, 1'b1);
    send_item(32'h5555_AAAA, 3'd5, 32'd0, 1'b0);
    send_item(32'hAAAA_5555, 3'd6, 32'hFFFF_FFFF, 1'b1);
    send_item(32'h0F0F_F0F0, 3'd4, 32'd5, 1'b0);
    send_item(32'h1234_5680, 3'd1, 32'd5, 1'b1);
    send_item(32'h0000_0000, 3'd0, 32'd0, 1'b0);
    send_item(32'hFFFF_8000, 3'd2, 32'd6, 1'b1);
  endtask

  // Mostly well-formed messages with random content; some carry a wrong seed length,
  // odd byte counts on inner items, oversized counts or a trailing zero-byte item.
  task automatic test_random_messages();
    int               nbytes;
    int               nwords;
    int               rem;
    shf_pkg::word_t   len;
    shf_pkg::nbytes_t nb;
    bit               zero_tail;
    while (items_sent < RANDOM_ITEMS) begin
      nbytes = ($urandom_range(0, 15) == 0) ? $urandom_range(41, 200) : $urandom_range(0, 40);
      len = ($urandom_range(0, 3) == 0) ? shf_pkg::word_t'($urandom)
                                        : shf_pkg::word_t'(nbytes);
      if (nbytes == 0) begin
        send_item($urandom, 3'd0, len, 1'b1);
      end else begin
        nwords = (nbytes + 3) / 4;
        rem = nbytes - 4 * (nwords - 1);
        zero_tail = (rem == 4) && ($urandom_range(0, 5) == 0);
        for (int i = 0; i < nwords; i++) begin
          nb = shf_pkg::FULL_BYTES;
          if ($urandom_range(0, 7) == 0) nb = shf_pkg::nbytes_t'($urandom_range(0, 7));
          if (i == nwords - 1 && !zero_tail) begin
            nb = shf_pkg::nbytes_t'(rem);
            if (rem == 4 && $urandom_range(0, 3) == 0)
              nb = shf_pkg::nbytes_t'($urandom_range(4, 7));
          end
          send_item($urandom, nb, len, (i == nwords - 1) && !zero_tail);
        end
        if (zero_tail) send_item($urandom, 3'd0, len, 1'b1);
      end
    end
  endtask

  initial begin : result_checker
    int             stall;
    shf_pkg::hash_t want;
    out_pop <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = draw_gap(pop_run_left, pop_quiet);
      if (stall > 0) begin
        out_pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      if (expected_hashes.size() == 0) begin
        report_failure($sformatf("unexpected hash %h", out_hash_value));
      end else begin
        want = expected_hashes.pop_front();
        if (out_hash_value !== want)
          report_failure($sformatf("hash_value expected %h, got %h", want, out_hash_value));
      end
    end
  end

  initial begin
    running_hash = '0;
    inside_msg = 1'b0;
    mismatch_count = 0;
    items_sent = 0;
    push_run_left = 0;
    pop_run_left = 0;
    rst_n             <= 1'b0;
    in_push           <= 1'b0;
    in_data_word      <= '0;
    in_valid_bytes    <= '0;
    in_message_length <= '0;
    in_last_word      <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_item_messages();
    test_multi_word_messages();
    test_random_messages();
    in_push <= 1'b0;
    while (expected_hashes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // If the test has not finished by this timeout, report mismatches and stop.
  initial begin
    #2ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
